>>> rtl/ass_pkg.sv
// Package for the arrive/seek steering unit: register indexes and widths.
// No dependencies.
`default_nettype none
package ass_pkg;
  localparam int unsigned CfgWidth = 31;
  localparam int unsigned CfgIdxWidth = 1;
  localparam logic [CfgIdxWidth-1:0] RegMaxSpeed = 1'b0;
  localparam logic [CfgIdxWidth-1:0] RegDecelRate = 1'b1;
  localparam logic [CfgWidth-1:0] MaxSpeedReset = 31'd6553600;

  // Mode flags carried down the pipeline with each item.
  typedef struct packed {
    logic arrive;
    logic zero_len;
  } mode_t;
endpackage
`default_nettype wire

>>> rtl/ass_stream_if.sv
// Valid/ready channel interface with a packed payload.
// Depends on nothing.
`default_nettype none
interface ass_stream_if #(
  parameter int unsigned W = 8
);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/ass_sqrt_stage.sv
// One bit of a restoring integer square root, registered, with a stall enable.
// Depends on nothing; chained by ass_core.
`default_nettype none
module ass_sqrt_stage #(
  parameter int unsigned NW = 66,
  parameter int unsigned RW = 33,
  parameter int unsigned BIT = 0
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [NW-1:0] rem_i,
  input  wire logic [RW-1:0] root_i,
  output logic      [NW-1:0] rem_o,
  output logic      [RW-1:0] root_o
);
  logic [NW+1:0] trial;
  logic [NW+1:0] rem_ext;

  // Try root bit BIT: (2r + 2^BIT) * 2^BIT against the remainder.
  always_comb begin
    trial = (({2'b0, {(NW-RW){1'b0}}, root_i}) << (BIT + 1))
          + ((NW+2)'(1) << (2 * BIT));
    rem_ext = {2'b0, rem_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (trial <= rem_ext) begin
        rem_o <= NW'(rem_ext - trial);
        root_o <= root_i | (RW'(1) << BIT);
      end else begin
        rem_o <= rem_i;
        root_o <= root_i;
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/ass_div_stage.sv
// One quotient bit of a restoring divider, registered, with a stall enable.
// Depends on nothing; chained by ass_core.
`default_nettype none
module ass_div_stage #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 33
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [DW:0]   rem_i,
  input  wire logic [NW-1:0] num_i,
  output logic      [DW:0]   rem_o,
  output logic      [NW-1:0] num_o
);
  logic [DW+1:0] shifted;

  // Shift the next numerator bit in; the quotient fills the low end.
  always_comb shifted = {rem_i, num_i[NW-1]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (shifted >= {2'b0, den_i}) begin
        rem_o <= (DW+1)'(shifted - {2'b0, den_i});
        num_o <= {num_i[NW-2:0], 1'b1};
      end else begin
        rem_o <= shifted[DW:0];
        num_o <= {num_i[NW-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/ass_core.sv
// Pipelined datapath: difference, squares, square root, speed divide,
// scale divides and saturation. Depends on ass_pkg, ass_sqrt_stage, ass_div_stage.
`default_nettype none
module ass_core #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic [6*DATA_WIDTH-1:0]      in_i,
  input  wire logic [ass_pkg::CfgWidth-1:0] max_speed_i,
  input  wire logic [ass_pkg::CfgWidth-1:0] decel_i,
  output logic                              valid_o,
  output logic      [2*DATA_WIDTH:0]        out_o
);
  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned MW = DW + 1;        // direction magnitude width
  localparam int unsigned SW = 2 * MW + 1;    // sum of squares width
  localparam int unsigned NW = SW + 1;        // padded to an even width
  localparam int unsigned RW = NW / 2;        // root width
  localparam int unsigned CW = ass_pkg::CfgWidth;
  localparam int unsigned PW = MW + CW;       // magnitude times speed
  localparam int unsigned SNW = RW + FRAC_BITS;
  localparam int unsigned SD = RW;            // sqrt stages
  localparam int unsigned DD = SNW;           // speed divide stages
  localparam int unsigned QD = PW;            // scale divide stages
  localparam int unsigned L = 3 + SD + DD + 2 + QD + 1;

  // Side data that rides along with each item.
  typedef struct packed {
    logic [MW-1:0] ax;
    logic [MW-1:0] ay;
    logic          sx;
    logic          sy;
    logic [DW-1:0] vx;
    logic [DW-1:0] vy;
    logic [CW-1:0] ms;
    logic [CW-1:0] dr;
  } side_t;

  logic [L-1:0] v_q;
  side_t s0_q, s1_q, s2_q;
  logic [2*MW-1:0] sqx_q, sqy_q;
  logic [NW-1:0] srem [SD+1];
  logic [RW-1:0] sroot [SD+1];
  side_t ss [SD+1];
  logic [RW:0] drem [DD+1];
  logic [SNW-1:0] dnum [DD+1];
  side_t ds [DD+1];
  logic [RW-1:0] dlen [DD+1];
  logic [RW-1:0] len_q, len2_q;
  side_t t_q, t2_q;
  logic [CW-1:0] spd_q;
  logic [PW-1:0] px_q, py_q;
  logic [RW:0] xrem [QD+1];
  logic [PW-1:0] xnum [QD+1];
  logic [RW:0] yrem [QD+1];
  logic [PW-1:0] ynum [QD+1];
  side_t qs [QD+1];
  logic [RW-1:0] qlen [QD+1];
  ass_pkg::mode_t qm [QD+1];
  logic [DW-1:0] fx_q, fy_q;
  logic sat_q;

  logic signed [MW-1:0] dx, dy;
  always_comb begin
    dx = MW'($signed(in_i[0+:DW])) - MW'($signed(in_i[2*DW+:DW]));
    dy = MW'($signed(in_i[DW+:DW])) - MW'($signed(in_i[3*DW+:DW]));
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en_i) v_q <= {v_q[L-2:0], valid_i};
  end
  assign valid_o = v_q[L-1];

  // Stage 1: differences and magnitudes. Stage 2: squares. Stage 3: sum.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_q.ax <= dx[MW-1] ? MW'(-dx) : MW'(dx);
      s0_q.ay <= dy[MW-1] ? MW'(-dy) : MW'(dy);
      s0_q.sx <= dx[MW-1];
      s0_q.sy <= dy[MW-1];
      s0_q.vx <= in_i[4*DW+:DW];
      s0_q.vy <= in_i[5*DW+:DW];
      s0_q.ms <= max_speed_i;
      s0_q.dr <= decel_i;
      sqx_q <= {{MW{1'b0}}, s0_q.ax} * {{MW{1'b0}}, s0_q.ax};
      sqy_q <= {{MW{1'b0}}, s0_q.ay} * {{MW{1'b0}}, s0_q.ay};
      s1_q <= s0_q;
      s2_q <= s1_q;
    end
  end
  logic [NW-1:0] sum_q;
  always_ff @(posedge clk_i) begin
    if (en_i) sum_q <= NW'(sqx_q) + NW'(sqy_q);
  end

  // Square root, one root bit per stage.
  assign srem[0] = sum_q;
  assign sroot[0] = '0;
  assign ss[0] = s2_q;
  for (genvar i = 0; i < SD; i++) begin : g_sqrt
    ass_sqrt_stage #(.NW(NW), .RW(RW), .BIT(SD - 1 - i)) u_st (
      .clk_i, .en_i, .rem_i(srem[i]), .root_i(sroot[i]),
      .rem_o(srem[i+1]), .root_o(sroot[i+1])
    );
    always_ff @(posedge clk_i) if (en_i) ss[i+1] <= ss[i];
  end

  // Arrive speed: (len << FRAC_BITS) / decel_rate.
  assign drem[0] = '0;
  assign dnum[0] = {sroot[SD], {FRAC_BITS{1'b0}}};
  assign ds[0] = ss[SD];
  assign dlen[0] = sroot[SD];
  for (genvar i = 0; i < DD; i++) begin : g_spd
    ass_div_stage #(.NW(SNW), .DW(RW)) u_dv (
      .clk_i, .en_i, .den_i(RW'(ds[i].dr)), .rem_i(drem[i]), .num_i(dnum[i]),
      .rem_o(drem[i+1]), .num_o(dnum[i+1])
    );
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ds[i+1] <= ds[i];
        dlen[i+1] <= dlen[i];
      end
    end
  end

  // Select and clamp the speed, then form |d| * speed.
  logic arr_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q <= ds[DD];
      len_q <= dlen[DD];
      arr_q <= ds[DD].dr != '0;
      if (ds[DD].dr == '0 || dnum[DD] > SNW'(ds[DD].ms)) spd_q <= ds[DD].ms;
      else spd_q <= CW'(dnum[DD]);
      px_q <= PW'(t_q.ax) * PW'(spd_q);
      py_q <= PW'(t_q.ay) * PW'(spd_q);
      t2_q <= t_q;
      len2_q <= len_q;
    end
  end
  logic arr2_q;
  always_ff @(posedge clk_i) if (en_i) arr2_q <= arr_q;

  // Scale divides by the length, both components in parallel.
  assign xrem[0] = '0;
  assign yrem[0] = '0;
  assign xnum[0] = px_q;
  assign ynum[0] = py_q;
  assign qs[0] = t2_q;
  assign qlen[0] = len2_q;
  assign qm[0] = '{arrive: arr2_q, zero_len: len2_q == '0};
  for (genvar i = 0; i < QD; i++) begin : g_scl
    ass_div_stage #(.NW(PW), .DW(RW)) u_dx (
      .clk_i, .en_i, .den_i(qlen[i]), .rem_i(xrem[i]), .num_i(xnum[i]),
      .rem_o(xrem[i+1]), .num_o(xnum[i+1])
    );
    ass_div_stage #(.NW(PW), .DW(RW)) u_dy (
      .clk_i, .en_i, .den_i(qlen[i]), .rem_i(yrem[i]), .num_i(ynum[i]),
      .rem_o(yrem[i+1]), .num_o(ynum[i+1])
    );
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        qs[i+1] <= qs[i];
        qlen[i+1] <= qlen[i];
        qm[i+1] <= qm[i];
      end
    end
  end

  // Subtract velocity and saturate.
  localparam int unsigned FW = PW + 2;
  logic signed [FW-1:0] desx, desy, rx, ry;
  logic ox, oy;
  logic [DW-1:0] cx, cy;
  localparam logic signed [FW-1:0] Hi = FW'((FW'(1) << (DW - 1)) - 1);
  localparam logic signed [FW-1:0] Lo = -Hi - FW'(1);
  always_comb begin
    desx = qm[QD].zero_len ? '0 : FW'(xnum[QD]);
    desy = qm[QD].zero_len ? '0 : FW'(ynum[QD]);
    if (qs[QD].sx) desx = -desx;
    if (qs[QD].sy) desy = -desy;
    rx = desx - FW'($signed(qs[QD].vx));
    ry = desy - FW'($signed(qs[QD].vy));
    ox = (rx > Hi) || (rx < Lo);
    oy = (ry > Hi) || (ry < Lo);
    cx = (rx > Hi) ? DW'(Hi) : (rx < Lo) ? DW'(Lo) : DW'(rx);
    cy = (ry > Hi) ? DW'(Hi) : (ry < Lo) ? DW'(Lo) : DW'(ry);
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (qm[QD].arrive && qm[QD].zero_len) begin
        fx_q <= '0;
        fy_q <= '0;
        sat_q <= 1'b0;
      end else begin
        fx_q <= cx;
        fy_q <= cy;
        sat_q <= ox | oy;
      end
    end
  end
  assign out_o = {sat_q, fy_q, fx_q};
endmodule
`default_nettype wire

>>> rtl/arrive_seek_steering_unit.sv
// Top level of the arrive/seek steering unit: registers and stall control.
// Depends on ass_pkg, ass_stream_if and ass_core.
//
// Channel   Direction  Payload
// in_if     sink       target_x, target_y, origin_x, origin_y, vel_x, vel_y
// out_if    source     force_x, force_y, saturated
// cfg       write      max_speed (index 0), decel_rate (index 1)
//
// One item per cycle while out_if takes each finished result; the pipeline depth is
// set by the bit-per-stage square root and the speed and scale dividers.
// Reset clears the valid bits and loads the register defaults.
// The whole pipeline holds while a finished result waits for its transfer.
`default_nettype none
module arrive_seek_steering_unit #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  ass_stream_if.sink                           in_if,
  ass_stream_if.source                         out_if,
  input  wire logic                            cfg_we_i,
  input  wire logic [ass_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  wire logic [ass_pkg::CfgWidth-1:0]    cfg_data_i
);
  logic [ass_pkg::CfgWidth-1:0] max_speed_q, decel_q;
  logic en, core_valid;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= ass_pkg::MaxSpeedReset;
      decel_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ass_pkg::RegMaxSpeed: max_speed_q <= cfg_data_i;
        ass_pkg::RegDecelRate: decel_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance unless a finished result is waiting for a transfer.
  assign en = !core_valid || out_if.ready;
  assign in_if.ready = en;
  assign out_if.valid = core_valid;

  ass_core #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_core (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_if.valid), .in_i(in_if.data),
    .max_speed_i(max_speed_q), .decel_i(decel_q),
    .valid_o(core_valid), .out_o(out_if.data)
  );
endmodule
`default_nettype wire
